[sv/tftprr_pkg.sv]
package tftprr_pkg;

   localparam int unsigned MAX_SEGMENT = 2048;
   localparam int unsigned SEG_FIELD_MAX = 4095;
   localparam logic [11:0] SEG_CAP =
      12'((MAX_SEGMENT > SEG_FIELD_MAX) ? SEG_FIELD_MAX : MAX_SEGMENT);
   localparam logic [11:0] HDR_BYTES = 12'd4;
   localparam logic [3:0] RETRY_LIMIT_RESET = 4'd10;
   localparam logic [11:0] SEGMENT_RESET = 12'd512;

   localparam logic [15:0] OPC_DATA = 16'd3;
   localparam logic [15:0] OPC_ERROR = 16'd5;
   localparam logic [15:0] OPC_OACK = 16'd6;

   typedef enum logic [1:0] {
      OP_START   = 2'd0,
      OP_PACKET  = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_ABORT   = 2'd3
   } op_type;

   typedef enum logic [0:0] {
      CSR_RETRY_LIMIT     = 1'b0,
      CSR_DEFAULT_SEGMENT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_REPORT  = 3'd0,
      ACT_REQUEST = 3'd1,
      ACT_ACK     = 3'd2,
      ACT_NAK     = 3'd3,
      ACT_DELIVER = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      NAK_GENERIC = 2'd0,
      NAK_BLOCK   = 2'd1,
      NAK_ABORT   = 2'd3
   } nak_type;

   typedef enum logic [2:0] {
      OUT_RUNNING        = 3'd0,
      OUT_FINISHED       = 3'd1,
      OUT_NOT_EXIST      = 3'd2,
      OUT_SERVER_ERROR   = 3'd3,
      OUT_PROTOCOL_ERROR = 3'd4,
      OUT_NO_ANSWER      = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      K_START,
      K_ABORT,
      K_RETRY,
      K_DATA,
      K_ERROR,
      K_OACK,
      K_BAD_OPTION,
      K_OTHER
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] block;
      logic        not_exist;
      logic [11:0] seg;
      logic [11:0] payload;
   } cmd_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] ack_block;
      nak_type     nak_code;
      logic [11:0] data_length;
      outcome_type outcome;
      logic        last;
   } rsp_type;

endpackage

[sv/tftprr_ifs.sv]
interface tftprr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [11:0] pkt_length;
   logic [15:0] opcode;
   logic [15:0] block_number;
   logic [15:0] blksize_option;
   logic        says_not_exist;

   modport source (
      output valid, op, pkt_length, opcode, block_number, blksize_option, says_not_exist,
      input  ready
   );
   modport sink (
      input  valid, op, pkt_length, opcode, block_number, blksize_option, says_not_exist,
      output ready
   );
endinterface

interface tftprr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] ack_block;
   logic [1:0]  nak_code;
   logic [11:0] data_length;
   logic [2:0]  outcome;
   logic        last;

   modport source (
      output valid, action, ack_block, nak_code, data_length, outcome, last,
      input  ready
   );
   modport sink (
      input  valid, action, ack_block, nak_code, data_length, outcome, last,
      output ready
   );
endinterface

[sv/tftprr_front.sv]
module tftprr_front import tftprr_pkg::*; (
   tftprr_req_if.sink req_bus,
   output logic       cmd_valid,
   input  logic       cmd_ready,
   output cmd_type    cmd_data
);

   op_type op;

   assign op = op_type'(req_bus.op);
   assign cmd_valid = req_bus.valid;
   assign req_bus.ready = cmd_ready;

   always_comb begin
      cmd_data.block = req_bus.block_number;
      cmd_data.not_exist = req_bus.says_not_exist;
      cmd_data.payload = req_bus.pkt_length - HDR_BYTES;
      cmd_data.seg = (req_bus.blksize_option > 16'(SEG_CAP)) ? SEG_CAP
                                                             : req_bus.blksize_option[11:0];
      if (op == OP_START) begin
         cmd_data.kind = K_START;
      end else if (op == OP_ABORT) begin
         cmd_data.kind = K_ABORT;
      end else if (op == OP_TIMEOUT || req_bus.pkt_length < HDR_BYTES) begin
         cmd_data.kind = K_RETRY;
      end else if (req_bus.opcode == OPC_DATA) begin
         cmd_data.kind = K_DATA;
      end else if (req_bus.opcode == OPC_ERROR) begin
         cmd_data.kind = K_ERROR;
      end else if (req_bus.opcode == OPC_OACK) begin
         cmd_data.kind = (req_bus.blksize_option == 16'd0) ? K_BAD_OPTION : K_OACK;
      end else begin
         cmd_data.kind = K_OTHER;
      end
   end

endmodule

[sv/tftprr_queue.sv]
module tftprr_queue import tftprr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);

   cmd_type            ent_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = ent_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            ent_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[sv/tftprr_back.sv]
module tftprr_back import tftprr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   tftprr_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_FIRST,
      PH_XFER
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] exp_ff, exp_in;
   logic [11:0] seg_ff, seg_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        ackm_ff, ackm_in;
   logic [3:0]  limit_ff;
   logic [11:0] dseg_ff;

   rsp_type     rsp_ff, pend_ff;
   logic        rsp_valid_ff, pend_valid_ff;
   rsp_type     res0_in, res1_in;
   logic [1:0]  nres;

   logic        out_free;
   logic        fire;
   logic        do_retry;
   logic        do_deliver;
   logic        retry_from_zero;
   logic [3:0]  limit;
   logic [3:0]  try_cnt;
   logic [11:0] pay;
   logic        is_short;
   outcome_type del_outcome;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign cmd_ready = out_free && !pend_valid_ff;
   assign fire = cmd_valid && cmd_ready;

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.action = rsp_ff.action;
   assign rsp_bus.ack_block = rsp_ff.ack_block;
   assign rsp_bus.nak_code = rsp_ff.nak_code;
   assign rsp_bus.data_length = rsp_ff.data_length;
   assign rsp_bus.outcome = rsp_ff.outcome;
   assign rsp_bus.last = rsp_ff.last;

   assign limit = (limit_ff == 4'd0) ? 4'd1 : limit_ff;
   assign pay = (cmd_data.payload > seg_ff) ? seg_ff : cmd_data.payload;
   assign is_short = cmd_data.payload < seg_ff;
   assign del_outcome = is_short ? OUT_FINISHED : OUT_RUNNING;

   always_comb begin
      phase_in = phase_ff;
      exp_in = exp_ff;
      seg_in = seg_ff;
      cnt_in = cnt_ff;
      ackm_in = ackm_ff;
      res0_in = '0;
      res1_in = '0;
      res0_in.last = 1'b1;
      res1_in.last = 1'b1;
      nres = 2'd0;
      do_retry = 1'b0;
      do_deliver = 1'b0;
      retry_from_zero = 1'b0;

      if (cmd_data.kind == K_START) begin
         phase_in = PH_FIRST;
         exp_in = '0;
         seg_in = dseg_ff;
         cnt_in = '0;
         ackm_in = 1'b0;
         res0_in.action = ACT_REQUEST;
         nres = 2'd1;
      end else if (phase_ff != PH_IDLE) begin
         nres = 2'd1;
         phase_in = PH_IDLE;
         res0_in.action = ACT_NAK;
         res0_in.nak_code = NAK_GENERIC;
         res0_in.outcome = OUT_PROTOCOL_ERROR;
         case (cmd_data.kind)
            K_ABORT: begin
               res0_in.nak_code = NAK_ABORT;
               res0_in.outcome = OUT_RUNNING;
            end
            K_RETRY: do_retry = 1'b1;
            K_ERROR: begin
               if (phase_ff == PH_FIRST) begin
                  res0_in.action = ACT_REPORT;
                  res0_in.outcome = cmd_data.not_exist ? OUT_NOT_EXIST : OUT_SERVER_ERROR;
               end else begin
                  res0_in.outcome = OUT_SERVER_ERROR;
               end
            end
            K_OACK: begin
               if (phase_ff == PH_FIRST) begin
                  seg_in = cmd_data.seg;
                  ackm_in = 1'b1;
                  retry_from_zero = 1'b1;
                  do_retry = 1'b1;
               end
            end
            K_DATA: begin
               if (phase_ff == PH_FIRST) begin
                  exp_in = 16'd1;
                  if (cmd_data.block != 16'd1) begin
                     res0_in.nak_code = NAK_BLOCK;
                  end else begin
                     do_deliver = 1'b1;
                  end
               end else if ({1'b0, cmd_data.block} == {1'b0, exp_ff} + 17'd1) begin
                  exp_in = cmd_data.block;
                  do_deliver = 1'b1;
               end else begin
                  do_retry = 1'b1;
               end
            end
            default: ;
         endcase
      end

      try_cnt = (retry_from_zero ? 4'd0 : cnt_ff) + 4'd1;
      if (do_retry) begin
         cnt_in = try_cnt;
         res0_in = '0;
         res0_in.last = 1'b1;
         if (try_cnt >= limit) begin
            phase_in = PH_IDLE;
            res0_in.outcome = OUT_NO_ANSWER;
         end else begin
            phase_in = phase_ff;
            if (phase_ff == PH_FIRST && !ackm_in) begin
               res0_in.action = ACT_REQUEST;
            end else begin
               res0_in.action = ACT_ACK;
               res0_in.ack_block = exp_ff;
            end
         end
      end

      if (do_deliver) begin
         nres = 2'd2;
         cnt_in = '0;
         phase_in = is_short ? PH_IDLE : PH_XFER;
         res0_in.action = ACT_DELIVER;
         res0_in.ack_block = cmd_data.block;
         res0_in.nak_code = NAK_GENERIC;
         res0_in.data_length = pay;
         res0_in.outcome = del_outcome;
         res0_in.last = 1'b0;
         res1_in.action = ACT_ACK;
         res1_in.ack_block = cmd_data.block;
         res1_in.outcome = del_outcome;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         exp_ff <= '0;
         seg_ff <= SEGMENT_RESET;
         cnt_ff <= '0;
         ackm_ff <= 1'b0;
         limit_ff <= RETRY_LIMIT_RESET;
         dseg_ff <= SEGMENT_RESET;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_RETRY_LIMIT:     limit_ff <= csr_wdata[3:0];
               CSR_DEFAULT_SEGMENT: dseg_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (out_free) begin
            if (pend_valid_ff) begin
               rsp_ff <= pend_ff;
               rsp_valid_ff <= 1'b1;
               pend_valid_ff <= 1'b0;
            end else if (fire) begin
               phase_ff <= phase_in;
               exp_ff <= exp_in;
               seg_ff <= seg_in;
               cnt_ff <= cnt_in;
               ackm_ff <= ackm_in;
               rsp_ff <= res0_in;
               pend_ff <= res1_in;
               rsp_valid_ff <= (nres != 2'd0);
               pend_valid_ff <= (nres == 2'd2);
            end else begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

endmodule

[sv/tftp_read_receiver.sv]
// Channel  Dir  Handshake      Payload
// req_bus  in   valid/ready    op, pkt_length, opcode, block_number, blksize_option,
//                              says_not_exist
// rsp_bus  out  valid/ready    action, ack_block, nak_code, data_length, outcome, last
// csr_*    in   csr_write      csr_index, csr_wdata (no read-back)
//
// One transaction per cycle for events with one result while rsp_bus is ready; a
// delivered block gives two results, sent one after the other through the single
// output register of the executor. A request is registered in the command queue
// and then in the output register before its earliest result transaction.
// Reset is synchronous: clears queue, transfer state and output; csr values return
// to retry limit 10 and segment size 512.
// A two-entry command queue separates classifier and executor, so rsp stalls do
// not block req until the queue fills.
module tftp_read_receiver import tftprr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tftprr_req_if.sink   req_bus,
   tftprr_rsp_if.source rsp_bus,
   input  logic         csr_write,
   input  logic         csr_index,
   input  logic [11:0]  csr_wdata
);

   logic    fq_valid, fq_ready;
   cmd_type fq_data;
   logic    qb_valid, qb_ready;
   cmd_type qb_data;

   tftprr_front u_front (
      .req_bus   (req_bus),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd_data  (fq_data)
   );

   tftprr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   tftprr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd_data  (qb_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_bus   (rsp_bus)
   );

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_deliver_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.action == ACT_DELIVER) |-> !rsp_bus.last)
      else $error("delivery marked last");

   a_ack_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last) |=>
         (rsp_bus.valid && rsp_bus.last && rsp_bus.action == ACT_ACK))
      else $error("no ack after delivery");

   a_pair_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.last) |=> rsp_bus.valid)
      else $error("second result lost");

endmodule

[tb/sv/tftprr_checker.sv]
`timescale 1ns / 100ps

module tftprr_checker import tftprr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tftprr_req_if       req_mon,
   tftprr_rsp_if       rsp_mon,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   output int          mismatches,
   output int          rsp_due,
   output int          events_answered
);

   typedef enum logic [1:0] {
      XF_IDLE,
      XF_FIRST,
      XF_TRANSFER
   } xfer_phase_type;

   xfer_phase_type phase;
   logic [15:0] next_block;
   logic [11:0] seg_size;
   logic [3:0]  tries;
   logic        oack_seen;
   logic [3:0]  try_limit;
   logic [11:0] dflt_seg;
   rsp_type     cmds_due[$];
   rsp_type     got_rsp;
   rsp_type     want_rsp;
   int          due_before;

   function automatic void push_cmd(action_type act, logic [15:0] blk, nak_type code,
                                    logic [11:0] dlen, outcome_type res, logic fin);
      rsp_type r;
      r.action      = act;
      r.ack_block   = blk;
      r.nak_code    = code;
      r.data_length = dlen;
      r.outcome     = res;
      r.last        = fin;
      cmds_due.push_back(r);
   endfunction

   // one more try: give up, or resend the last command
   function automatic void count_try();
      logic [3:0] lim;
      lim   = (try_limit == 4'd0) ? 4'd1 : try_limit;
      tries = tries + 4'd1;
      if (tries >= lim) begin
         phase = XF_IDLE;
         push_cmd(ACT_REPORT, 16'd0, NAK_GENERIC, 12'd0, OUT_NO_ANSWER, 1'b1);
      end else if (phase == XF_FIRST && !oack_seen) begin
         push_cmd(ACT_REQUEST, 16'd0, NAK_GENERIC, 12'd0, OUT_RUNNING, 1'b1);
      end else begin
         push_cmd(ACT_ACK, next_block, NAK_GENERIC, 12'd0, OUT_RUNNING, 1'b1);
      end
   endfunction

   function automatic void nak_stop(nak_type code, outcome_type res);
      phase = XF_IDLE;
      push_cmd(ACT_NAK, 16'd0, code, 12'd0, res, 1'b1);
   endfunction

   function automatic void deliver_block(logic [11:0] len);
      logic [11:0] payload;
      logic        is_short;
      outcome_type res;
      payload = len - HDR_BYTES;
      if (payload > seg_size)
         payload = seg_size;
      is_short = payload < seg_size;
      res = is_short ? OUT_FINISHED : OUT_RUNNING;
      push_cmd(ACT_DELIVER, next_block, NAK_GENERIC, payload, res, 1'b0);
      push_cmd(ACT_ACK, next_block, NAK_GENERIC, 12'd0, res, 1'b1);
      phase = is_short ? XF_IDLE : XF_TRANSFER;
      tries = 4'd0;
   endfunction

   function automatic void step_receiver(op_type op, logic [11:0] len, logic [15:0] opc,
                                         logic [15:0] blk, logic [15:0] bs, logic ne);
      int unsigned seg;
      if (op == OP_START) begin
         phase      = XF_FIRST;
         next_block = 16'd0;
         seg_size   = dflt_seg;
         tries      = 4'd0;
         oack_seen  = 1'b0;
         push_cmd(ACT_REQUEST, 16'd0, NAK_GENERIC, 12'd0, OUT_RUNNING, 1'b1);
      end else if (phase == XF_IDLE) begin
         // ignored while idle
      end else if (op == OP_ABORT) begin
         nak_stop(NAK_ABORT, OUT_RUNNING);
      end else if (op == OP_TIMEOUT || len < HDR_BYTES) begin
         count_try();
      end else if (phase == XF_FIRST) begin
         if (opc == OPC_ERROR) begin
            phase = XF_IDLE;
            push_cmd(ACT_REPORT, 16'd0, NAK_GENERIC, 12'd0,
                     ne ? OUT_NOT_EXIST : OUT_SERVER_ERROR, 1'b1);
         end else if (opc == OPC_OACK) begin
            if (bs == 16'd0) begin
               nak_stop(NAK_GENERIC, OUT_PROTOCOL_ERROR);
            end else begin
               seg = bs;
               if (seg > MAX_SEGMENT)
                  seg = MAX_SEGMENT;
               if (seg > SEG_FIELD_MAX)
                  seg = SEG_FIELD_MAX;
               seg_size  = 12'(seg);
               oack_seen = 1'b1;
               tries     = 4'd0;
               count_try();
            end
         end else if (opc == OPC_DATA) begin
            next_block = 16'd1;
            if (blk != 16'd1)
               nak_stop(NAK_BLOCK, OUT_PROTOCOL_ERROR);
            else
               deliver_block(len);
         end else begin
            nak_stop(NAK_GENERIC, OUT_PROTOCOL_ERROR);
         end
      end else begin
         if (opc == OPC_DATA) begin
            // no wrap: after block 65535 nothing is the next block
            if ({1'b0, blk} == {1'b0, next_block} + 17'd1) begin
               next_block = blk;
               deliver_block(len);
            end else begin
               count_try();
            end
         end else if (opc == OPC_ERROR) begin
            nak_stop(NAK_GENERIC, OUT_SERVER_ERROR);
         end else begin
            nak_stop(NAK_GENERIC, OUT_PROTOCOL_ERROR);
         end
      end
   endfunction

   function automatic void flag(string why, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display({"%0t: %s: expected act=%0d blk=%0d nak=%0d len=%0d out=%0d last=%0b,",
                   " got act=%0d blk=%0d nak=%0d len=%0d out=%0d last=%0b"},
                  $time, why, want.action, want.ack_block, want.nak_code,
                  want.data_length, want.outcome, want.last, got.action,
                  got.ack_block, got.nak_code, got.data_length, got.outcome, got.last);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         phase           = XF_IDLE;
         next_block      = 16'd0;
         try_limit       = RETRY_LIMIT_RESET;
         dflt_seg        = SEGMENT_RESET;
         seg_size        = SEGMENT_RESET;
         tries           = 4'd0;
         oack_seen       = 1'b0;
         mismatches      = 0;
         events_answered = 0;
         cmds_due.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_rsp.action      = action_type'(rsp_mon.action);
            got_rsp.ack_block   = rsp_mon.ack_block;
            got_rsp.nak_code    = nak_type'(rsp_mon.nak_code);
            got_rsp.data_length = rsp_mon.data_length;
            got_rsp.outcome     = outcome_type'(rsp_mon.outcome);
            got_rsp.last        = rsp_mon.last;
            if (cmds_due.size() == 0) begin
               flag("unexpected transaction", '0, got_rsp);
            end else begin
               want_rsp = cmds_due.pop_front();
               if (got_rsp !== want_rsp)
                  flag("mismatch", want_rsp, got_rsp);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            due_before = cmds_due.size();
            step_receiver(op_type'(req_mon.op), req_mon.pkt_length, req_mon.opcode,
                          req_mon.block_number, req_mon.blksize_option,
                          req_mon.says_not_exist);
            if (cmds_due.size() > due_before)
               events_answered++;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_RETRY_LIMIT: begin
                  try_limit = csr_wdata[3:0];
               end
               CSR_DEFAULT_SEGMENT: begin
                  dflt_seg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
      end
      rsp_due = cmds_due.size();
   end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import tftprr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic        csr_index;
   logic [11:0] csr_wdata;

   int          mismatches;
   int          rsp_due;
   int          events_answered;
   int          burst_left;
   int unsigned cycles;
   logic        want_hold;
   logic        hold_taken;
   logic [11:0] cur_dflt;
   logic [11:0] cur_seg;

   tftprr_req_if req_bus();
   tftprr_rsp_if rsp_bus();

   tftp_read_receiver u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tftprr_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .rsp_due         (rsp_due),
      .events_answered (events_answered)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: changing ready patterns, one long hold-off on request
   initial begin
      int rdy_mode;
      int rdy_left;
      logic toggle;
      rsp_bus.ready <= 1'b0;
      hold_taken = 1'b0;
      rdy_mode   = 0;
      rdy_left   = 0;
      toggle     = 1'b0;
      forever begin
         @(negedge clock);
         if (want_hold && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_bus.ready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++)
               @(negedge clock);
         end
         if (rdy_left <= 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(16, 80);
         end
         rdy_left--;
         toggle = ~toggle;
         case (rdy_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= toggle;
            2: rsp_bus.ready <= ($urandom_range(0, 99) >= 40);
            default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   function automatic logic [15:0] any16();
      return 16'($urandom);
   endfunction

   task automatic send_event(op_type op, int unsigned len, logic [15:0] opc,
                             logic [15:0] blk, logic [15:0] bs, logic ne);
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
      end
      req_bus.valid          <= 1'b1;
      req_bus.op             <= op;
      req_bus.pkt_length     <= 12'(len);
      req_bus.opcode         <= opc;
      req_bus.block_number   <= blk;
      req_bus.blksize_option <= bs;
      req_bus.says_not_exist <= ne;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_data(logic [15:0] blk, int unsigned len);
      send_event(OP_PACKET, len, OPC_DATA, blk, any16(), 1'($urandom));
   endtask

   task automatic send_ctl(op_type op);
      send_event(op, $urandom, any16(), any16(), any16(), 1'($urandom));
   endtask

   // drain: nothing pending, then let the block settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (rsp_due != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [11:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
      if (idx == CSR_DEFAULT_SEGMENT)
         cur_dflt = val;
   endtask

   task automatic set_config(logic [11:0] limit, logic [11:0] seg);
      wait_idle();
      write_csr(CSR_RETRY_LIMIT, limit);
      write_csr(CSR_DEFAULT_SEGMENT, seg);
   endtask

   task automatic run_transfer();
      int unsigned pick;
      int unsigned blocks;
      int unsigned len;
      logic [15:0] bs;
      send_ctl(OP_START);
      cur_seg = cur_dflt;
      if ($urandom_range(0, 99) < 8)
         send_ctl(OP_TIMEOUT);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         send_event(OP_PACKET, $urandom_range(4, 200), OPC_ERROR, any16(), any16(),
                    1'($urandom));
         return;
      end
      if (pick < 9) begin
         send_data(any16(), $urandom_range(4, 2052));
         return;
      end
      if (pick < 12) begin
         send_event(OP_PACKET, $urandom_range(4, 4095), any16(), any16(), any16(),
                    1'($urandom));
         return;
      end
      if (pick < 50) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            bs = 16'd0;
         else if (pick < 40)
            bs = 16'($urandom_range(8, 64));
         else if (pick < 60)
            bs = 16'($urandom_range(2049, 65535));
         else
            bs = 16'($urandom_range(65, 2048));
         send_event(OP_PACKET, $urandom_range(4, 4095), OPC_OACK, any16(), bs,
                    1'($urandom));
         if (bs == 16'd0)
            return;
         cur_seg = (bs > 16'd2048) ? 12'd2048 : bs[11:0];
      end
      blocks = $urandom_range(0, 5);
      for (int unsigned b = 1; b <= blocks + 1; b++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_ctl(OP_ABORT);
            return;
         end else if (pick < 9) begin
            send_ctl(OP_TIMEOUT);
         end else if (pick < 12) begin
            send_event(OP_PACKET, $urandom_range(0, 3), any16(), any16(), any16(),
                       1'($urandom));
         end else if (pick < 18 && b > 1) begin
            send_data(16'(b - 1), cur_seg + 4);
         end else if (pick < 20 && b > 1) begin
            send_event(OP_PACKET, $urandom_range(4, 100), OPC_ERROR, any16(), any16(),
                       1'($urandom));
            return;
         end else if (pick < 22 && b > 1) begin
            send_event(OP_PACKET, $urandom_range(4, 100), OPC_OACK, any16(), any16(),
                       1'($urandom));
            return;
         end
         if (b == blocks + 1)
            len = $urandom_range(0, cur_seg - 1) + 4;
         else if ($urandom_range(0, 99) < 85)
            len = cur_seg + 4;
         else
            len = cur_seg + 4 + $urandom_range(1, 4091 - cur_seg);
         send_data(16'(b), len);
      end
   endtask

   task automatic random_phase(int target);
      int start_count;
      start_count = events_answered;
      while (events_answered - start_count < target) begin
         if ($urandom_range(0, 99) < 85)
            run_transfer();
         else
            send_event(op_type'($urandom_range(0, 3)), $urandom,
                       ($urandom_range(0, 1) == 0) ? any16()
                                                   : 16'($urandom_range(3, 6)),
                       any16(), any16(), 1'($urandom));
      end
   endtask

   initial begin
      req_bus.valid          <= 1'b0;
      req_bus.op             <= OP_START;
      req_bus.pkt_length     <= 12'd0;
      req_bus.opcode         <= 16'd0;
      req_bus.block_number   <= 16'd0;
      req_bus.blksize_option <= 16'd0;
      req_bus.says_not_exist <= 1'b0;
      csr_write              <= 1'b0;
      csr_index              <= CSR_RETRY_LIMIT;
      csr_wdata              <= 12'd0;
      reset                  <= 1'b1;
      burst_left = 0;
      want_hold  = 1'b0;
      cur_dflt   = SEGMENT_RESET;
      cur_seg    = SEGMENT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset settings: limit 10, segment 512
      send_event(OP_TIMEOUT, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_event(OP_ABORT, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_event(OP_START, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_event(OP_TIMEOUT, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_event(OP_PACKET, 3, OPC_DATA, 16'd1, 16'd0, 1'b0);
      send_event(OP_PACKET, 20, OPC_OACK, 16'd0, 16'd0, 1'b0);
      send_event(OP_START, 4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_event(OP_PACKET, 20, OPC_OACK, 16'd0, 16'hFFFF, 1'b0);
      send_event(OP_TIMEOUT, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_data(16'd1, 2052);
      send_data(16'd1, 2052);
      send_data(16'd2, 4095);
      send_data(16'd3, 4);
      send_event(OP_START, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_event(OP_PACKET, 30, OPC_ERROR, 16'd0, 16'd0, 1'b1);
      send_event(OP_START, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_event(OP_PACKET, 30, OPC_ERROR, 16'd0, 16'd0, 1'b0);
      send_event(OP_START, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_data(16'd2, 516);
      send_event(OP_START, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_event(OP_START, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_event(OP_PACKET, 30, 16'hFFFF, 16'd1, 16'd512, 1'b0);
      send_event(OP_START, 0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_data(16'd1, 516);
      send_event(OP_ABORT, 0, 16'd0, 16'd0, 16'd0, 1'b0);

      set_config(12'd1, 12'd8);
      want_hold = 1'b1;
      random_phase(70);
      set_config(12'd15, 12'd2048);
      random_phase(70);
      // limit zero behaves as one
      set_config(12'd0, 12'd100);
      random_phase(50);
      set_config(12'd4, 12'd9);
      random_phase(70);
      set_config(12'd15, 12'd8);
      random_phase(70);
      set_config(12'd7, 12'd512);
      random_phase(70);

      req_bus.valid <= 1'b0;
      while (rsp_due != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0 && rsp_due == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
